/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a on a clock edge implies condition c on the same edge
`define CALT_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("calt check failed");

// condition a on a clock edge implies condition c on the next edge
`define CALT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("calt check failed");

`endif

/* src/calt_pkg.sv */
// shared constants, types and tables of the arc-length table block
package calt_pkg;

  localparam int CALT_MAX_DEPTH = 5;
  localparam int CALT_GAUSS_POINTS = 5;
  localparam int UW = 17;
  localparam int LW = 48;
  localparam int QW = 56;
  localparam int CW = 32;
  localparam int AW = 5;
  localparam int NCOEF = 6;
  localparam int QB_STEPS = 12;
  localparam logic [UW-1:0] U_ONE = 17'd65536;
  localparam logic [31:0] TOL_RESET = 32'd655;

  // register indexes
  localparam logic [2:0] REG_AX = 3'd0;
  localparam logic [2:0] REG_AY = 3'd1;
  localparam logic [2:0] REG_BX = 3'd2;
  localparam logic [2:0] REG_BY = 3'd3;
  localparam logic [2:0] REG_CX = 3'd4;
  localparam logic [2:0] REG_CY = 3'd5;
  localparam logic [2:0] REG_TOL = 3'd6;

  // gauss-legendre nodes q0.30 and weights q0.24, rounded from ten decimals
  localparam logic [63:0] DEC = 64'd10000000000;
  localparam logic [63:0] HALF = 64'd5000000000;
  localparam logic [29:0] NODE0 = 30'((64'd1488743389 * (64'd1 << 30) + HALF) / DEC);
  localparam logic [29:0] NODE1 = 30'((64'd4333953941 * (64'd1 << 30) + HALF) / DEC);
  localparam logic [29:0] NODE2 = 30'((64'd6794095682 * (64'd1 << 30) + HALF) / DEC);
  localparam logic [29:0] NODE3 = 30'((64'd8650633666 * (64'd1 << 30) + HALF) / DEC);
  localparam logic [29:0] NODE4 = 30'((64'd9739065285 * (64'd1 << 30) + HALF) / DEC);
  localparam logic [23:0] WGT0 = 24'((64'd2955242247 * (64'd1 << 24) + HALF) / DEC);
  localparam logic [23:0] WGT1 = 24'((64'd2692667193 * (64'd1 << 24) + HALF) / DEC);
  localparam logic [23:0] WGT2 = 24'((64'd2190863625 * (64'd1 << 24) + HALF) / DEC);
  localparam logic [23:0] WGT3 = 24'((64'd1494513491 * (64'd1 << 24) + HALF) / DEC);
  localparam logic [23:0] WGT4 = 24'((64'd666713443 * (64'd1 << 24) + HALF) / DEC);

  // scale codes for the speed-squared coefficients
  localparam logic [2:0] SC_1 = 3'd0;
  localparam logic [2:0] SC_4 = 3'd1;
  localparam logic [2:0] SC_6 = 3'd2;
  localparam logic [2:0] SC_9 = 3'd3;
  localparam logic [2:0] SC_12 = 3'd4;

  typedef logic [NCOEF-1:0][CW-1:0] coef_bank_t;

  typedef struct packed {
    logic go;
    logic build;
    logic [UW-1:0] a;
    logic [UW-1:0] b;
  } eng_req_t;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic [2:0] tgt;
    logic [2:0] scale;
    logic grp_end;
  } qb_step_t;

  function automatic logic [29:0] gl_node(input logic [2:0] idx);
    logic [29:0] v;
    case (idx)
      3'd0: v = NODE0;
      3'd1: v = NODE1;
      3'd2: v = NODE2;
      3'd3: v = NODE3;
      default: v = NODE4;
    endcase
    return v;
  endfunction

  function automatic logic [23:0] gl_weight(input logic [2:0] idx);
    logic [23:0] v;
    case (idx)
      3'd0: v = WGT0;
      3'd1: v = WGT1;
      3'd2: v = WGT2;
      3'd3: v = WGT3;
      default: v = WGT4;
    endcase
    return v;
  endfunction

  // product schedule for the speed-squared polynomial, grouped by target
  function automatic qb_step_t qb_step(input logic [3:0] k);
    qb_step_t s;
    case (k)
      4'd0: s = '{REG_AX, REG_AX, 3'd4, SC_9, 1'b0};
      4'd1: s = '{REG_AY, REG_AY, 3'd4, SC_9, 1'b1};
      4'd2: s = '{REG_AX, REG_BX, 3'd3, SC_12, 1'b0};
      4'd3: s = '{REG_AY, REG_BY, 3'd3, SC_12, 1'b1};
      4'd4: s = '{REG_AX, REG_CX, 3'd2, SC_6, 1'b0};
      4'd5: s = '{REG_AY, REG_CY, 3'd2, SC_6, 1'b0};
      4'd6: s = '{REG_BX, REG_BX, 3'd2, SC_4, 1'b0};
      4'd7: s = '{REG_BY, REG_BY, 3'd2, SC_4, 1'b1};
      4'd8: s = '{REG_BX, REG_CX, 3'd1, SC_4, 1'b0};
      4'd9: s = '{REG_BY, REG_CY, 3'd1, SC_4, 1'b1};
      4'd10: s = '{REG_CX, REG_CX, 3'd0, SC_1, 1'b0};
      default: s = '{REG_CY, REG_CY, 3'd0, SC_1, 1'b1};
    endcase
    return s;
  endfunction

  function automatic logic signed [QW-1:0] qb_scale(input logic signed [47:0] p,
                                                   input logic [2:0] code);
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] r;
    x = QW'(p);
    case (code)
      SC_4: r = x <<< 2;
      SC_6: r = (x <<< 2) + (x <<< 1);
      SC_9: r = (x <<< 3) + x;
      SC_12: r = (x <<< 3) + (x <<< 2);
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

/* src/calt_mul.sv */
// shared registered signed multiplier
module calt_mul import calt_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic signed [65:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

/* src/calt_sqrt.sv */
// bit-serial restoring square root, two radicand bits per cycle
module calt_sqrt import calt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [53:0] x,
  output logic        done,
  output logic [34:0] root
);

  logic [69:0] xs;
  logic [37:0] rem;
  logic [5:0]  cnt;
  logic        running;
  logic [37:0] rem_next;
  logic [37:0] trial;

  assign rem_next = {rem[35:0], xs[69:68]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xs <= {x, 16'b0};
        rem <= '0;
        root <= '0;
        cnt <= 6'd35;
        running <= 1'b1;
      end else if (running) begin
        xs <= {xs[67:0], 2'b00};
        if (rem_next >= trial) begin
          rem <= rem_next - trial;
          root <= {root[33:0], 1'b1};
        end else begin
          rem <= rem_next;
          root <= {root[33:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/calt_eng.sv */
// quadrature engine: polynomial build and 10-point estimate on one multiplier
module calt_eng import calt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  eng_req_t      req,
  input  coef_bank_t    coefs,
  output logic          done,
  output logic [LW-1:0] result
);

  localparam logic [3:0] E_IDLE = 4'd0;
  localparam logic [3:0] E_QB_MUL = 4'd1;
  localparam logic [3:0] E_QB_ACC = 4'd2;
  localparam logic [3:0] E_ND_MUL = 4'd3;
  localparam logic [3:0] E_ND_POS = 4'd4;
  localparam logic [3:0] E_H1 = 4'd5;
  localparam logic [3:0] E_H2 = 4'd6;
  localparam logic [3:0] E_H3 = 4'd7;
  localparam logic [3:0] E_SQ = 4'd8;
  localparam logic [3:0] E_W1 = 4'd9;
  localparam logic [3:0] E_W2 = 4'd10;
  localparam logic [3:0] E_W3 = 4'd11;
  localparam logic [3:0] E_F1 = 4'd12;
  localparam logic [3:0] E_F2 = 4'd13;
  localparam logic [3:0] E_F3 = 4'd14;

  logic [3:0]             state;
  logic [UW-1:0]          a_r, b_r, d, u_cur, um_r;
  logic [3:0]             step;
  logic [2:0]             pt;
  logic [1:0]             hstep;
  logic                   side;
  logic signed [QW-1:0]   q;
  logic signed [QW-1:0]   qc [5];
  logic signed [QW-1:0]   bacc;
  logic signed [QW+1:0]   hi_term;
  logic [35:0]            ssum;
  logic [41:0]            whi;
  logic [62:0]            acc;
  logic [39:0]            fhi;
  logic signed [32:0]     op_a, op_b;
  logic signed [65:0]     prod;
  logic                   sq_start, sq_done;
  logic [53:0]            sq_x;
  logic [34:0]            sq_root;

  qb_step_t               qs;
  logic signed [47:0]     p16;
  logic signed [QW-1:0]   bacc_new;
  logic [31:0]            dx;
  logic [32:0]            center;
  logic [33:0]            up_sum, um_sum;
  logic signed [QW-1:0]   qc_h;
  logic signed [QW+1:0]   qn;
  logic [64:0]            fsum;

  calt_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod(prod));

  calt_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x(sq_x), .done(sq_done), .root(sq_root)
  );

  assign qs = qb_step(step);
  assign p16 = prod[63:16];
  assign bacc_new = bacc + qb_scale(p16, qs.scale);
  assign dx = prod[46:15];
  assign center = {({1'b0, a_r} + {1'b0, b_r}), 15'b0};
  assign up_sum = {1'b0, center} + {2'b0, dx} + 34'd32768;
  assign um_sum = {1'b0, center} - {2'b0, dx} + 34'd32768;
  assign qc_h = qc[{1'b0, hstep}];
  assign qn = {{2{qc_h[QW-1]}}, qc_h} + hi_term + {29'b0, prod[44:16]};
  assign fsum = {1'b0, fhi, 24'b0} + {24'b0, prod[40:0]} + 65'd16777216;
  assign sq_start = (state == E_H3) && (hstep == 2'd0);

  // clamp speed squared to [0, 2^54-1]
  always_comb begin
    if (qn < 0) begin
      sq_x = '0;
    end else if (qn > $signed({4'b0, {54{1'b1}}})) begin
      sq_x = {54{1'b1}};
    end else begin
      sq_x = qn[53:0];
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      E_QB_MUL: begin
        op_a = {coefs[qs.a_sel][CW-1], coefs[qs.a_sel]};
        op_b = {coefs[qs.b_sel][CW-1], coefs[qs.b_sel]};
      end
      E_ND_MUL: begin
        op_a = {16'b0, d};
        op_b = {3'b0, gl_node(pt)};
      end
      E_H1: begin
        op_a = {{5{q[QW-1]}}, q[55:28]};
        op_b = {16'b0, u_cur};
      end
      E_H2: begin
        op_a = {5'b0, q[27:0]};
        op_b = {16'b0, u_cur};
      end
      E_W1: begin
        op_a = {15'b0, ssum[35:18]};
        op_b = {9'b0, gl_weight(pt)};
      end
      E_W2: begin
        op_a = {15'b0, ssum[17:0]};
        op_b = {9'b0, gl_weight(pt)};
      end
      E_F1: begin
        op_a = {10'b0, acc[62:40]};
        op_b = {16'b0, d};
      end
      E_F2: begin
        op_a = {9'b0, acc[39:16]};
        op_b = {16'b0, d};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        qc[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (req.go) begin
            if (req.build) begin
              for (int i = 0; i < 5; i++) begin
                qc[i] <= '0;
              end
              bacc <= '0;
              step <= '0;
              state <= E_QB_MUL;
            end else begin
              a_r <= req.a;
              b_r <= req.b;
              d <= req.b - req.a;
              acc <= '0;
              pt <= '0;
              state <= E_ND_MUL;
            end
          end
        end
        E_QB_MUL: state <= E_QB_ACC;
        E_QB_ACC: begin
          if (qs.grp_end) begin
            qc[qs.tgt] <= bacc_new;
            bacc <= '0;
          end else begin
            bacc <= bacc_new;
          end
          if (step == 4'(QB_STEPS - 1)) begin
            done <= 1'b1;
            state <= E_IDLE;
          end else begin
            step <= step + 4'd1;
            state <= E_QB_MUL;
          end
        end
        E_ND_MUL: state <= E_ND_POS;
        E_ND_POS: begin
          u_cur <= up_sum[32:16];
          um_r <= um_sum[32:16];
          side <= 1'b0;
          q <= qc[4];
          hstep <= 2'd3;
          ssum <= '0;
          state <= E_H1;
        end
        E_H1: state <= E_H2;
        E_H2: begin
          hi_term <= {prod[45:0], 12'b0};
          state <= E_H3;
        end
        E_H3: begin
          if (hstep == 2'd0) begin
            state <= E_SQ;
          end else begin
            q <= qn[QW-1:0];
            hstep <= hstep - 2'd1;
            state <= E_H1;
          end
        end
        E_SQ: begin
          if (sq_done) begin
            ssum <= ssum + {1'b0, sq_root};
            if (!side) begin
              side <= 1'b1;
              u_cur <= um_r;
              q <= qc[4];
              hstep <= 2'd3;
              state <= E_H1;
            end else begin
              state <= E_W1;
            end
          end
        end
        E_W1: state <= E_W2;
        E_W2: begin
          whi <= prod[41:0];
          state <= E_W3;
        end
        E_W3: begin
          acc <= acc + {3'b0, whi, 18'b0} + {21'b0, prod[41:0]};
          if (pt == 3'(CALT_GAUSS_POINTS - 1)) begin
            state <= E_F1;
          end else begin
            pt <= pt + 3'd1;
            state <= E_ND_MUL;
          end
        end
        E_F1: state <= E_F2;
        E_F2: begin
          fhi <= prod[39:0];
          state <= E_F3;
        end
        E_F3: begin
          result <= {8'b0, fsum[64:25]};
          done <= 1'b1;
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

/* src/cubic_arc_length_table_top.sv */
// top level: register port, adaptive split control, pending stack, result words
//
// usage
//   configuration: apb-style port, coef_ax..coef_cy at 0x00..0x14, error_tolerance
//   at 0x18. a coefficient write rebuilds the speed-squared polynomial on the shared
//   multiplier; busy stays high until that is done.
//   request: pulse start with u_start/u_end while busy is low. values above 1.0 are
//   taken as 1.0 and a reversed interval collapses to its start.
//   results: each table word shows for one cycle with valid high; the receiver
//   cannot stall. two words per accepted leaf (midpoint, end point), left to right,
//   last_entry marks the final word of the request.
//   work: each quadrature runs the 35-step square root twice per gauss node and
//   shares the single multiplier. a request needs three quadratures plus four per
//   split (two for each half), the most when every branch splits down to MAX_DEPTH.
//   reset: coefficients and polynomial clear, tolerance returns to 655, no words
//   are pending.
module cubic_arc_length_table_top import calt_pkg::*; #(
  parameter int MAX_DEPTH = CALT_MAX_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  // request channel
  input  logic          start,
  output logic          busy,
  input  logic [UW-1:0] u_start,
  input  logic [UW-1:0] u_end,
  // result channel
  output logic          valid,
  output logic [UW-1:0] u_point,
  output logic [LW-1:0] cumulative_length,
  output logic          depth_limited,
  output logic          last_entry,
  // configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int SPW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BUILD = 3'd1;
  localparam logic [2:0] S_EST = 3'd2;
  localparam logic [2:0] S_LEFT = 3'd3;
  localparam logic [2:0] S_RIGHT = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_EMIT1 = 3'd6;
  localparam logic [2:0] S_EMIT2 = 3'd7;

  // configuration registers
  coef_bank_t    coefs;
  logic [31:0]   tol_reg;
  logic          rebuild_pend;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;

  // request state
  logic [2:0]     state;
  logic [UW-1:0]  a, b;
  logic [LW-1:0]  est, left, right, running;
  logic [31:0]    tol;
  logic [SPW-1:0] depth, sp;
  logic [6:0]     entries;
  logic           flag;

  // pending right halves
  logic [UW-1:0]  pend_m [MAX_DEPTH];
  logic [UW-1:0]  pend_b [MAX_DEPTH];
  logic [LW-1:0]  pend_est [MAX_DEPTH];
  logic [31:0]    pend_tol [MAX_DEPTH];
  logic [SPW-1:0] pend_depth [MAX_DEPTH];

  // engine
  eng_req_t       eng_req;
  logic           eng_done;
  logic [LW-1:0]  eng_res;

  logic [UW-1:0]  a_in, b_in, m_w, m_split, m_pop;
  logic [SPW-1:0] sp_dec;
  logic [IW-1:0]  top_idx;
  logic [LW:0]    sum_lr;
  logic [LW+1:0]  diff, err;
  logic           err_gt, split;
  logic [LW-1:0]  run_left;

  function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] x, input logic [LW-1:0] y);
    logic [LW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[LW] ? {LW{1'b1}} : s[LW-1:0];
  endfunction

  calt_eng u_eng (
    .clk(clk), .rst(rst), .req(eng_req), .coefs(coefs), .done(eng_done), .result(eng_res)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];
  assign busy = (state != S_IDLE) || rebuild_pend;

  always_comb begin
    unique case (cfg_idx)
      REG_AX, REG_AY, REG_BX, REG_BY, REG_CX, REG_CY: prdata = coefs[cfg_idx];
      REG_TOL: prdata = tol_reg;
      default: prdata = '0;
    endcase
  end

  // clamp request bounds to 1.0, reversed interval collapses
  always_comb begin
    logic [UW-1:0] bc;
    a_in = (u_start > U_ONE) ? U_ONE : u_start;
    bc = (u_end > U_ONE) ? U_ONE : u_end;
    b_in = (bc < a_in) ? a_in : bc;
  end

  assign m_w = 17'(({1'b0, a} + {1'b0, b}) >> 1);
  assign m_split = 17'(({1'b0, a} + {1'b0, m_w}) >> 1);
  assign sp_dec = sp - SPW'(1);
  assign top_idx = sp_dec[IW-1:0];
  assign m_pop = 17'(({1'b0, pend_m[top_idx]} + {1'b0, pend_b[top_idx]}) >> 1);

  // error of the split against the parent estimate
  assign sum_lr = {1'b0, left} + {1'b0, right};
  assign diff = {2'b0, est} - {1'b0, sum_lr};
  assign err = diff[LW+1] ? (~diff + 1'b1) : diff;
  assign err_gt = err > {18'b0, tol};
  assign split = err_gt && (depth < SPW'(MAX_DEPTH)) && (sp < SPW'(MAX_DEPTH));

  assign run_left = sat_add(running, left);

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
      tol_reg <= TOL_RESET;
      rebuild_pend <= 1'b0;
      state <= S_IDLE;
      valid <= 1'b0;
      eng_req <= '0;
    end else begin
      valid <= 1'b0;
      eng_req.go <= 1'b0;

      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_AX, REG_AY, REG_BX, REG_BY, REG_CX, REG_CY: begin
            coefs[cfg_idx] <= pwdata;
            rebuild_pend <= 1'b1;
          end
          REG_TOL: tol_reg <= pwdata;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start && !busy) begin
            a <= a_in;
            b <= b_in;
            running <= '0;
            tol <= tol_reg;
            depth <= '0;
            sp <= '0;
            entries <= '0;
            eng_req <= '{go: 1'b1, build: 1'b0, a: a_in, b: b_in};
            state <= S_EST;
          end else if (rebuild_pend) begin
            // a coefficient write in this same cycle keeps the flag set for another pass
            if (!(cfg_wr && cfg_idx < REG_TOL)) begin
              rebuild_pend <= 1'b0;
            end
            eng_req <= '{go: 1'b1, build: 1'b1, a: '0, b: '0};
            state <= S_BUILD;
          end
        end
        S_BUILD: begin
          if (eng_done) begin
            state <= S_IDLE;
          end
        end
        S_EST: begin
          if (eng_done) begin
            est <= eng_res;
            eng_req <= '{go: 1'b1, build: 1'b0, a: a, b: m_w};
            state <= S_LEFT;
          end
        end
        S_LEFT: begin
          if (eng_done) begin
            left <= eng_res;
            eng_req <= '{go: 1'b1, build: 1'b0, a: m_w, b: b};
            state <= S_RIGHT;
          end
        end
        S_RIGHT: begin
          if (eng_done) begin
            right <= eng_res;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (split) begin
            // push right half, descend into left half
            pend_m[sp[IW-1:0]] <= m_w;
            pend_b[sp[IW-1:0]] <= b;
            pend_est[sp[IW-1:0]] <= right;
            pend_tol[sp[IW-1:0]] <= tol >> 1;
            pend_depth[sp[IW-1:0]] <= depth + SPW'(1);
            sp <= sp + SPW'(1);
            b <= m_w;
            est <= left;
            tol <= tol >> 1;
            depth <= depth + SPW'(1);
            eng_req <= '{go: 1'b1, build: 1'b0, a: a, b: m_split};
            state <= S_LEFT;
          end else begin
            flag <= err_gt;
            state <= (entries > 7'd62) ? S_IDLE : S_EMIT1;
          end
        end
        S_EMIT1: begin
          valid <= 1'b1;
          u_point <= m_w;
          cumulative_length <= run_left;
          depth_limited <= flag;
          last_entry <= 1'b0;
          running <= run_left;
          entries <= entries + 7'd1;
          state <= S_EMIT2;
        end
        S_EMIT2: begin
          valid <= 1'b1;
          u_point <= b;
          cumulative_length <= sat_add(running, right);
          depth_limited <= flag;
          last_entry <= (sp == '0);
          running <= sat_add(running, right);
          entries <= entries + 7'd1;
          if (sp == '0) begin
            state <= S_IDLE;
          end else begin
            // pop the next pending right half
            sp <= sp_dec;
            a <= pend_m[top_idx];
            b <= pend_b[top_idx];
            est <= pend_est[top_idx];
            tol <= pend_tol[top_idx];
            depth <= pend_depth[top_idx];
            eng_req <= '{go: 1'b1, build: 1'b0, a: pend_m[top_idx], b: m_pop};
            state <= S_LEFT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/calt_chk.sv */
// port-level checker for the arc-length table block, bound to the top level
`include "assert_macros.svh"

module calt_chk import calt_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          valid,
  input logic [UW-1:0] u_point,
  input logic          last_entry,
  input logic          pready
);

  // an accepted request keeps the block busy
  `CALT_ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy, busy)

  // a word that is not the last one comes while the request is still running
  `CALT_ASSERT_NOW(a_mid_word_busy, clk, rst, valid && !last_entry, busy)

  // table points never pass 1.0
  `CALT_ASSERT_NOW(a_point_range, clk, rst, valid, u_point <= U_ONE)

  // last word ends the request: no word follows on the next cycle
  `CALT_ASSERT_NEXT(a_last_closes, clk, rst, valid && last_entry, !valid)

  // the register port never waits
  `CALT_ASSERT_NOW(a_ready, clk, rst, 1'b1, pready)

endmodule

bind cubic_arc_length_table_top calt_chk u_calt_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .valid(valid),
  .u_point(u_point), .last_entry(last_entry), .pready(pready)
);

/* sim/cubic_arc_length_table_top_test.sv */
// testbench for the arc-length table block: random cubics, split checking, word-level compare
`timescale 1ns / 1ps

module cubic_arc_length_table_top_test;
  import calt_pkg::*;

  localparam int WATCHDOG_LIMIT = 150000;
  localparam int ITEM_TARGET = 150;

  // one table word as the block should show it
  typedef struct {
    bit [UW-1:0] u;
    bit [LW-1:0] len;
    bit          dl;
    bit          last;
  } table_word_t;

  // scoreboard: mirrors the register file and predicts the table of each request
  class arc_table_board;
    longint      coef[NCOEF];
    bit [31:0]   tol_reg;
    longint      poly[5];
    table_word_t words_due[$];
    int          errors;

    function new();
      foreach (coef[i]) coef[i] = 0;
      tol_reg = TOL_RESET;
      errors = 0;
      rebuild();
    endfunction

    function longint mul16(longint a, longint b);
      return (a * b) >>> 16;
    endfunction

    // speed-squared polynomial from the cubic coefficients
    function void rebuild();
      poly[4] = 9 * (mul16(coef[REG_AX], coef[REG_AX]) + mul16(coef[REG_AY], coef[REG_AY]));
      poly[3] = 12 * (mul16(coef[REG_AX], coef[REG_BX]) + mul16(coef[REG_AY], coef[REG_BY]));
      poly[2] = 6 * (mul16(coef[REG_AX], coef[REG_CX]) + mul16(coef[REG_AY], coef[REG_CY]))
              + 4 * (mul16(coef[REG_BX], coef[REG_BX]) + mul16(coef[REG_BY], coef[REG_BY]));
      poly[1] = 4 * (mul16(coef[REG_BX], coef[REG_CX]) + mul16(coef[REG_BY], coef[REG_CY]));
      poly[0] = mul16(coef[REG_CX], coef[REG_CX]) + mul16(coef[REG_CY], coef[REG_CY]);
    endfunction

    function void set_reg(logic [2:0] idx, bit [31:0] val);
      if (idx == REG_TOL) tol_reg = val;
      else begin
        coef[idx] = longint'(signed'(val));
        rebuild();
      end
    endfunction

    // floor(v * u / 2^16), u at most 1.0
    function longint scale_u(longint v, longint u);
      longint h, l;
      h = v >>> 16;
      l = v - h * 65536;
      return h * u + ((l * u) >>> 16);
    endfunction

    // floor(sqrt(q * 2^16)) with q clamped to [0, 2^54-1]
    function bit [63:0] speed_at(longint u);
      longint    q;
      bit [71:0] qq;
      bit [63:0] root, rem, trial;
      q = poly[4];
      for (int i = 3; i >= 0; i--) q = poly[i] + scale_u(q, u);
      if (q < 0) q = 0;
      if (q > longint'((64'd1 << 54) - 1)) q = longint'((64'd1 << 54) - 1);
      qq = 72'(q) << 16;
      root = 0;
      rem = 0;
      for (int i = 34; i >= 0; i--) begin
        rem = (rem << 2) | 64'(qq[2*i +: 2]);
        trial = (root << 2) | 64'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          root = (root << 1) | 64'd1;
        end else begin
          root = root << 1;
        end
      end
      return root;
    endfunction

    // 10-point gauss-legendre estimate over [a,b]
    function bit [63:0] gauss_len(bit [63:0] a, bit [63:0] b);
      bit [63:0] d, center, hw, acc, dx, up, um;
      bit [63:0] nodes[5], wts[5];
      nodes = '{64'(NODE0), 64'(NODE1), 64'(NODE2), 64'(NODE3), 64'(NODE4)};
      wts = '{64'(WGT0), 64'(WGT1), 64'(WGT2), 64'(WGT3), 64'(WGT4)};
      d = b - a;
      center = (a + b) << 15;
      hw = d << 15;
      acc = 0;
      for (int i = 0; i < CALT_GAUSS_POINTS; i++) begin
        dx = (hw * nodes[i]) >> 30;
        up = (center + dx + 64'd32768) >> 16;
        um = (center - dx + 64'd32768) >> 16;
        acc += wts[i] * (speed_at(longint'(up)) + speed_at(longint'(um)));
      end
      return (((acc >> 16) * d) + (64'd1 << 24)) >> 25;
    endfunction

    function bit [63:0] sat_sum(bit [63:0] x, bit [63:0] y);
      bit [63:0] s;
      s = x + y;
      return (s > (64'd1 << 48) - 1) ? (64'd1 << 48) - 1 : s;
    endfunction

    // walk the adaptive split for one accepted request and queue its words
    function void note_request(bit [UW-1:0] us, bit [UW-1:0] ue);
      bit [63:0] a, b, m, est, lft, rgt, tol, run;
      bit [63:0] stk_a[CALT_MAX_DEPTH], stk_b[CALT_MAX_DEPTH];
      bit [63:0] stk_est[CALT_MAX_DEPTH], stk_tol[CALT_MAX_DEPTH];
      int        stk_depth[CALT_MAX_DEPTH];
      int        depth, sp, n;
      longint    err;
      bit        flag;
      table_word_t w;
      a = (us > U_ONE) ? 64'(U_ONE) : 64'(us);
      b = (ue > U_ONE) ? 64'(U_ONE) : 64'(ue);
      if (b < a) b = a;
      tol = 64'(tol_reg);
      depth = 0;
      sp = 0;
      n = 0;
      run = 0;
      est = gauss_len(a, b);
      forever begin
        m = (a + b) >> 1;
        lft = gauss_len(a, m);
        rgt = gauss_len(m, b);
        err = longint'(est) - longint'(lft + rgt);
        if (err < 0) err = -err;
        if (64'(err) > tol && depth < CALT_MAX_DEPTH && sp < CALT_MAX_DEPTH) begin
          // push the right half, descend into the left
          stk_a[sp] = m;
          stk_b[sp] = b;
          stk_est[sp] = rgt;
          stk_tol[sp] = tol >> 1;
          stk_depth[sp] = depth + 1;
          sp++;
          b = m;
          est = lft;
          tol = tol >> 1;
          depth++;
          continue;
        end
        flag = 64'(err) > tol;
        if (n > 62) break;
        run = sat_sum(run, lft);
        w = '{UW'(m), LW'(run), flag, 1'b0};
        words_due.push_back(w);
        run = sat_sum(run, rgt);
        w = '{UW'(b), LW'(run), flag, sp == 0};
        words_due.push_back(w);
        n += 2;
        if (sp == 0) break;
        sp--;
        a = stk_a[sp];
        b = stk_b[sp];
        est = stk_est[sp];
        tol = stk_tol[sp];
        depth = stk_depth[sp];
      end
    endfunction

    function void check_word(bit [UW-1:0] u, bit [LW-1:0] len, bit dl, bit last);
      table_word_t w;
      if (words_due.size() == 0) begin
        $display("%0t: unexpected word u_point=%0d cumulative_length=%0d", $time, u, len);
        errors++;
        return;
      end
      w = words_due.pop_front();
      if (u !== w.u) begin
        $display("%0t: u_point expected %0d actual %0d", $time, w.u, u);
        errors++;
      end
      if (len !== w.len) begin
        $display("%0t: cumulative_length expected %0d actual %0d", $time, w.len, len);
        errors++;
      end
      if (dl !== w.dl) begin
        $display("%0t: depth_limited expected %0d actual %0d", $time, w.dl, dl);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last_entry expected %0d actual %0d", $time, w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [UW-1:0] u_start = '0;
  logic [UW-1:0] u_end = '0;
  logic          valid;
  logic [UW-1:0] u_point;
  logic [LW-1:0] cumulative_length;
  logic          depth_limited;
  logic          last_entry;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  arc_table_board board = new();
  int            idle_cycles = 0;
  int            requests_sent = 0;

  cubic_arc_length_table_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .u_start(u_start), .u_end(u_end),
    .valid(valid), .u_point(u_point), .cumulative_length(cumulative_length),
    .depth_limited(depth_limited), .last_entry(last_entry), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // note accepted requests and check every result word at the edge that takes it
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_request(u_start, u_end);
      if (valid) board.check_word(u_point, cumulative_length, depth_limited, last_entry);
    end
  end

  // watchdog: too long without a request or a word being taken
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("FAIL cubic_arc_length_table_top");
      $finish;
    end
  end

  // apb write: setup then access cycle, then let the polynomial rebuild finish
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, val);
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold start with the interval until the block takes it; start stays high after
  task automatic send_request(logic [UW-1:0] a, logic [UW-1:0] b);
    start <= 1'b1;
    u_start <= a;
    u_end <= b;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  task automatic sender_gap(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // wait until every predicted word is out and the block is idle again
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.words_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_curve(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                            logic [31:0] by, logic [31:0] cx, logic [31:0] cy,
                            logic [31:0] tol);
    write_reg(REG_AX, ax);
    write_reg(REG_AY, ay);
    write_reg(REG_BX, bx);
    write_reg(REG_BY, by);
    write_reg(REG_CX, cx);
    write_reg(REG_CY, cy);
    write_reg(REG_TOL, tol);
  endtask

  // random coefficient: mostly a few units, sometimes zero or anything 32 bits allow
  function automatic logic [31:0] rand_coef();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = 32'h0;
      default: v = $urandom_range(0, 32'h0004_0000);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // random parameter: mostly within [0,1], sometimes any 17-bit value
  function automatic logic [UW-1:0] rand_u();
    return ($urandom_range(0, 4) == 0) ? UW'($urandom()) : UW'($urandom_range(0, 65536));
  endfunction

  initial begin
    int phase_items, burst_left, tol_kind;
    logic [31:0] tol;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // reset config: flat zero curve, clamping and reversed intervals
    send_request(17'd0, U_ONE);
    send_request(U_ONE, 17'd0);
    send_request(17'h1FFFF, 17'h1FFFF);
    send_request(17'd100, 17'd100);
    send_request(17'd65535, 17'h10001);
    drain();

    // coefficient extremes with the widest tolerance, no splitting
    load_curve(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(17'd0, U_ONE);
    send_request(17'd0, 17'd1);
    send_request(17'd32768, 17'h1FFFF);
    drain();

    // zero tolerance on a bent curve: splits all the way to the depth limit
    load_curve(32'h0003_0000, -32'sh0002_0000, -32'sh0004_0000, 32'h0001_8000,
               32'h0001_0000, 32'h0000_0000, 32'h0);
    send_request(17'd0, U_ONE);
    send_request(17'd1000, 17'd50000);
    drain();

    // modest tolerance: partial splits
    write_reg(REG_TOL, 32'd200);
    send_request(17'd0, U_ONE);
    sender_gap(7);
    send_request(17'd20000, 17'd20001);
    drain();

    // random curves in phases, bursts of requests with random gaps
    while (requests_sent < ITEM_TARGET) begin
      tol_kind = $urandom_range(0, 9);
      if (tol_kind == 0) tol = $urandom_range(0, 2000);
      else if (tol_kind < 5) tol = $urandom_range(2000, 400000);
      else tol = $urandom();
      load_curve(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                 rand_coef(), tol);
      phase_items = (tol_kind == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
      burst_left = $urandom_range(1, 6);
      repeat (phase_items) begin
        send_request(rand_u(), rand_u());
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 6);
          sender_gap($urandom_range(0, 3) == 0 ? $urandom_range(100, 3000)
                                               : $urandom_range(0, 40));
        end
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.words_due.size() == 0) begin
      $display("PASS cubic_arc_length_table_top");
    end else begin
      $display("FAIL cubic_arc_length_table_top");
    end
    $finish;
  end

endmodule
